[rtl/vci_pkg.sv]
// Package: breakpoint table, widths and pipeline token type for the charge interpolator.
`default_nettype none

package vci_pkg;

  localparam int MV_W  = 16;
  localparam int PCT_W = 7;

  // Rows of the breakpoint table and the number in use.
  localparam int TABLE_ENTRIES = 14;
  localparam int ROWS_AVAIL    = 14;
  localparam int NROWS = (TABLE_ENTRIES > ROWS_AVAIL) ? ROWS_AVAIL :
                         ((TABLE_ENTRIES < 2) ? 2 : TABLE_ENTRIES);
  localparam int NSEGS = ROWS_AVAIL - 1;
  localparam int SEG_W = 4;

  // Datapath widths: offset*100 stays below span*100 (max span 300 mV).
  localparam int NUM_W    = 15;
  localparam int RECIP_W  = 18;
  localparam int RECIP_SH = 24;
  localparam int RATIO_W  = 7;
  localparam int SPANP_W  = 4;
  localparam int SCL_W    = RATIO_W + SPANP_W;
  localparam int DIV100_W = 14;
  localparam int DIV100_SH = 20;
  localparam int QUO_W    = SCL_W + DIV100_W - DIV100_SH;

  localparam logic [MV_W-1:0] BP_MV [ROWS_AVAIL] = '{
    16'd4200, 16'd4100, 16'd4000, 16'd3900, 16'd3800, 16'd3700, 16'd3600,
    16'd3500, 16'd3400, 16'd3300, 16'd3200, 16'd3000, 16'd2800, 16'd2500
  };

  localparam logic [PCT_W-1:0] BP_PCT [ROWS_AVAIL] = '{
    7'd100, 7'd95, 7'd90, 7'd80, 7'd70, 7'd60, 7'd50,
    7'd40, 7'd30, 7'd20, 7'd15, 7'd10, 7'd5, 7'd0
  };

  // ceil(2^24 / voltage span) per segment; exact floor since num*span < 2^24.
  localparam logic [RECIP_W-1:0] SEG_RECIP [NSEGS] = '{
    18'd167773, 18'd167773, 18'd167773, 18'd167773, 18'd167773,
    18'd167773, 18'd167773, 18'd167773, 18'd167773, 18'd167773,
    18'd83887, 18'd83887, 18'd55925
  };

  // Charge drop across each segment.
  localparam logic [SPANP_W-1:0] SEG_SPANP [NSEGS] = '{
    4'd5, 4'd5, 4'd10, 4'd10, 4'd10, 4'd10, 4'd10,
    4'd10, 4'd10, 4'd5, 4'd5, 4'd5, 4'd5
  };

  // ceil(2^20 / 100): exact floor for products below 1024.
  localparam logic [DIV100_W-1:0] DIV100_M = 14'd10486;

  localparam logic [PCT_W-1:0] PCT_SCALE = 7'd100;

  typedef struct packed {
    logic             valid;
    logic             sat;
    logic [PCT_W-1:0] sat_pct;
    logic [SEG_W-1:0] seg;
  } tok_t;

endpackage

`default_nettype wire

[rtl/vci_locate.sv]
// Stage 1: segment search and saturation detect against the breakpoint table.
`default_nettype none

module vci_locate (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_valid,
  input  wire logic [vci_pkg::MV_W-1:0] in_mv,
  output vci_pkg::tok_t                 tok_o,
  output logic [vci_pkg::MV_W-1:0]      mv_o
);
  import vci_pkg::*;

  tok_t            tok_r, tok_nxt;
  logic [MV_W-1:0] mv_r;
  logic            hi_sat, lo_sat;
  logic [SEG_W-1:0] seg;

  always_comb begin
    hi_sat = (in_mv >= BP_MV[0]);
    lo_sat = (in_mv <= BP_MV[NROWS-1]);
    seg    = '0;
    for (int i = 0; i < NROWS - 1; i++) begin
      if (in_mv <= BP_MV[i] && in_mv > BP_MV[i+1]) begin
        seg = SEG_W'(i);
      end
    end
    tok_nxt.valid   = in_valid;
    tok_nxt.sat     = hi_sat | lo_sat;
    tok_nxt.sat_pct = hi_sat ? BP_PCT[0] : BP_PCT[NROWS-1];
    tok_nxt.seg     = seg;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r.valid <= 1'b0;
    end else begin
      tok_r.valid <= tok_nxt.valid;
    end
    tok_r.sat     <= tok_nxt.sat;
    tok_r.sat_pct <= tok_nxt.sat_pct;
    tok_r.seg     <= tok_nxt.seg;
    mv_r          <= in_mv;
  end

  assign tok_o = tok_r;
  assign mv_o  = mv_r;

endmodule

`default_nettype wire

[rtl/vci_ratio.sv]
// Stages 2-3: voltage offset scaled by 100, then divided by the segment span.
`default_nettype none

module vci_ratio (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire vci_pkg::tok_t            tok_i,
  input  wire logic [vci_pkg::MV_W-1:0] mv_i,
  output vci_pkg::tok_t                 tok_o,
  output logic [vci_pkg::RATIO_W-1:0]   ratio_o
);
  import vci_pkg::*;

  tok_t                        tok2_r, tok3_r;
  logic [NUM_W-1:0]            num_r, num_nxt;
  logic [RATIO_W-1:0]          ratio_r, ratio_nxt;
  logic [MV_W-1:0]             diff;
  logic [MV_W+PCT_W-1:0]       scaled;
  logic [NUM_W+RECIP_W-1:0]    prod;

  always_comb begin
    diff    = BP_MV[tok_i.seg] - mv_i;
    scaled  = (MV_W+PCT_W)'(diff) * (MV_W+PCT_W)'(PCT_SCALE);
    num_nxt = scaled[NUM_W-1:0];
  end

  // Reciprocal multiply; the quotient starts at bit RECIP_SH.
  always_comb begin
    prod      = (NUM_W+RECIP_W)'(num_r) * (NUM_W+RECIP_W)'(SEG_RECIP[tok2_r.seg]);
    ratio_nxt = prod[RECIP_SH +: RATIO_W];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok2_r.valid <= 1'b0;
      tok3_r.valid <= 1'b0;
    end else begin
      tok2_r.valid <= tok_i.valid;
      tok3_r.valid <= tok2_r.valid;
    end
    tok2_r.sat     <= tok_i.sat;
    tok2_r.sat_pct <= tok_i.sat_pct;
    tok2_r.seg     <= tok_i.seg;
    tok3_r.sat     <= tok2_r.sat;
    tok3_r.sat_pct <= tok2_r.sat_pct;
    tok3_r.seg     <= tok2_r.seg;
    num_r          <= num_nxt;
    ratio_r        <= ratio_nxt;
  end

  assign tok_o   = tok3_r;
  assign ratio_o = ratio_r;

endmodule

`default_nettype wire

[rtl/vci_scale.sv]
// Stages 4-5: ratio times charge span, divide by 100, subtract from the upper charge (or pass the saturated value).
`default_nettype none

module vci_scale (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire vci_pkg::tok_t           tok_i,
  input  wire logic [vci_pkg::RATIO_W-1:0] ratio_i,
  output logic                         out_valid,
  output logic [vci_pkg::PCT_W-1:0]    out_pct
);
  import vci_pkg::*;

  tok_t                        tok4_r;
  logic [SCL_W-1:0]            scl_r, scl_nxt;
  logic                        out_valid_r;
  logic [PCT_W-1:0]            out_pct_r, out_pct_nxt;
  logic [SCL_W+DIV100_W-1:0]   qprod;
  logic [QUO_W-1:0]            quo;

  always_comb begin
    scl_nxt = SCL_W'(ratio_i) * SCL_W'(SEG_SPANP[tok_i.seg]);
  end

  // Divide by 100 as a reciprocal multiply, then subtract from the upper charge or take the saturated value.
  always_comb begin
    qprod = (SCL_W+DIV100_W)'(scl_r) * (SCL_W+DIV100_W)'(DIV100_M);
    quo   = qprod[DIV100_SH +: QUO_W];
    if (tok4_r.sat) begin
      out_pct_nxt = tok4_r.sat_pct;
    end else begin
      out_pct_nxt = BP_PCT[tok4_r.seg] - PCT_W'(quo);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok4_r.valid <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      tok4_r.valid <= tok_i.valid;
      out_valid_r  <= tok4_r.valid;
    end
    tok4_r.sat     <= tok_i.sat;
    tok4_r.sat_pct <= tok_i.sat_pct;
    tok4_r.seg     <= tok_i.seg;
    scl_r          <= scl_nxt;
    out_pct_r      <= out_pct_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_pct   = out_pct_r;

endmodule

`default_nettype wire

[rtl/voltage_to_charge_interpolator.sv]
// Top level: cell voltage to state-of-charge interpolator pipeline.
// Takes one voltage sample per clock: busy is always low, and each sample
// accepted with start gives exactly one out_valid strobe, in order, with
// out_charge_percent valid for that single cycle. The pipeline has five
// register stages: segment search, offset scaling, span reciprocal
// multiply, charge-span multiply, and the divide-by-100 and subtract.
// Results cannot be held off, so the receiver must take each strobe. The
// breakpoint table is fixed; inputs at or above the top breakpoint read 100
// and at or below the bottom breakpoint read 0.
`default_nettype none

module voltage_to_charge_interpolator (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  output logic                            busy,
  input  wire logic [vci_pkg::MV_W-1:0]   in_voltage_mv,
  output logic                            out_valid,
  output logic [vci_pkg::PCT_W-1:0]       out_charge_percent
);
  import vci_pkg::*;

  tok_t                tok1, tok3;
  logic [MV_W-1:0]     mv1;
  logic [RATIO_W-1:0]  ratio3;
  logic                accept;

  assign busy   = 1'b0;
  assign accept = start & ~busy;

  vci_locate u_locate (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (accept),
    .in_mv    (in_voltage_mv),
    .tok_o    (tok1),
    .mv_o     (mv1)
  );

  vci_ratio u_ratio (
    .clk     (clk),
    .rst_n   (rst_n),
    .tok_i   (tok1),
    .mv_i    (mv1),
    .tok_o   (tok3),
    .ratio_o (ratio3)
  );

  vci_scale u_scale (
    .clk       (clk),
    .rst_n     (rst_n),
    .tok_i     (tok3),
    .ratio_i   (ratio3),
    .out_valid (out_valid),
    .out_pct   (out_charge_percent)
  );

endmodule

`default_nettype wire

[rtl/vci_checker.sv]
// Port-level checker for the charge interpolator, bound to the top level.
`default_nettype none

module vci_checker (
  input wire logic                     clk,
  input wire logic                     rst_n,
  input wire logic                     start,
  input wire logic                     busy,
  input wire logic [vci_pkg::MV_W-1:0] in_voltage_mv,
  input wire logic                     out_valid,
  input wire logic [vci_pkg::PCT_W-1:0] out_charge_percent
);
  import vci_pkg::*;

  // Every accepted item produces an out_valid result.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##5 out_valid)
    else $error("accepted item produced no result");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, 5))
    else $error("result without an accepted item");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_charge_percent <= PCT_SCALE))
    else $error("charge above 100 percent");

  a_sat_hi: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_voltage_mv >= BP_MV[0]) |-> ##5
      (out_charge_percent == BP_PCT[0]))
    else $error("high voltage did not read full charge");

  a_sat_lo: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_voltage_mv <= BP_MV[NROWS-1]) |-> ##5
      (out_charge_percent == BP_PCT[NROWS-1]))
    else $error("low voltage did not read empty");

endmodule

bind voltage_to_charge_interpolator vci_checker u_vci_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .start              (start),
  .busy               (busy),
  .in_voltage_mv      (in_voltage_mv),
  .out_valid          (out_valid),
  .out_charge_percent (out_charge_percent)
);

`default_nettype wire
